// ----- hdl/ble_pkg.sv -----
// ----------------------------------------------------------------------------
// ble_pkg: shared types and codes of the bounded list engine
// Field widths, command opcodes and response status codes used by the
// channel interfaces and the engine core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

  // payload field widths
  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 2;

  typedef logic [OP_W-1:0]     opcode_t;
  typedef logic [STATUS_W-1:0] status_t;

  // command opcodes
  localparam opcode_t OP_PUSH_FRONT = 2'd0;
  localparam opcode_t OP_PUSH_BACK  = 2'd1;
  localparam opcode_t OP_POP_BACK   = 2'd2;
  localparam opcode_t OP_DEL_BEFORE = 2'd3;

  // response status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_BADPOS = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

  // lowest position accepted by delete-before
  localparam logic [POS_W-1:0] POS_MIN = POS_W'(3);

endpackage

`default_nettype wire

// ----- hdl/ble_cmd_if.sv -----
// ----------------------------------------------------------------------------
// ble_cmd_if: command channel of the bounded list engine
// Valid/ready channel carrying opcode, value and position of one command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ble_cmd_if;
  logic                                valid;
  logic                                ready;
  ble_pkg::opcode_t                    opcode;
  logic signed [ble_pkg::DATA_W-1:0]   value;
  logic        [ble_pkg::POS_W-1:0]    position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

`default_nettype wire

// ----- hdl/ble_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ble_rsp_if: response channel of the bounded list engine
// Valid/ready channel carrying status, new length and removed value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ble_rsp_if;
  logic                                valid;
  logic                                ready;
  ble_pkg::status_t                    status;
  logic        [ble_pkg::LEN_W-1:0]    length;
  logic signed [ble_pkg::DATA_W-1:0]   removed_value;

  modport source (output valid, output status, output length, output removed_value,
                  input ready);
  modport sink   (input valid, input status, input length, input removed_value,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/bounded_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// bounded_list_engine_core: bounded ordered list of signed 32-bit values
// Ring of CAPACITY entries in one RAM; push front/back, pop back and
// delete-before-position, one response beat per command beat.
// ----------------------------------------------------------------------------
//   channel  dir  beat contents
//   cmd      in   opcode, value, position
//   rsp      out  status, length, removed_value
//
// Push runs EXEC then RESULT; pop back runs EXEC, POPRD, RESULT; delete
// before position p runs EXEC, VICTIM, SHIFT while elements remain, RESULT,
// with one RAM read and one RAM write per moved element.
// One command is in work at a time; cmd.ready is high only while idle. A
// waiting response beat stalls the next command only once its result is ready.
// Synchronous reset empties the list; RAM contents need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_engine_core #(
  parameter int CAPACITY = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  ble_cmd_if.sink    cmd,
  ble_rsp_if.source  rsp
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW + 1 > ble_pkg::POS_W + 1) ? CW + 1 : ble_pkg::POS_W + 1;
  localparam logic [IW:0]   CAP_W   = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_IX = IW'(CAPACITY - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_POPRD  = 3'd2;
  localparam logic [2:0] S_VICTIM = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]                  state, state_next;
  logic [IW-1:0]               front, front_next;
  logic [CW-1:0]               count, count_next;
  logic [IW-1:0]               idx, idx_next;
  ble_pkg::status_t            status_q, status_next;
  logic [ble_pkg::DATA_W-1:0]  removed_q, removed_next;
  ble_pkg::opcode_t            op_q;
  logic [ble_pkg::DATA_W-1:0]  val_q;
  logic [ble_pkg::POS_W-1:0]   pos_q;

  logic                        rsp_valid;
  ble_pkg::status_t            rsp_status;
  logic [ble_pkg::LEN_W-1:0]   rsp_length;
  logic [ble_pkg::DATA_W-1:0]  rsp_removed;
  logic                        rsp_load;

  logic                        mem_we;
  logic [IW-1:0]               mem_waddr;
  logic [ble_pkg::DATA_W-1:0]  mem_wdata;
  logic [IW-1:0]               mem_raddr;
  logic [ble_pkg::DATA_W-1:0]  mem_rdata;

  logic [IW-1:0]               front_dec;
  logic [ble_pkg::POS_W-1:0]   pos_off;
  logic                        pos_bad;
  logic [IW:0]                 idx_p1;
  logic [IW:0]                 idx_p2;

  // ring slot of a logical offset from the front
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                         input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= CAP_W) begin
      s = s - CAP_W;
    end
    return s[IW-1:0];
  endfunction

  ble_ram #(
    .WIDTH (ble_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // helper arithmetic
  assign front_dec = (front == '0) ? LAST_IX : front - 1'b1;
  assign pos_off   = pos_q - ble_pkg::POS_MIN;
  assign pos_bad   = (pos_q < ble_pkg::POS_MIN) ||
                     (CMPW'(pos_q) > CMPW'(count) + CMPW'(1));
  assign idx_p1    = {1'b0, idx} + (IW + 1)'(1);
  assign idx_p2    = {1'b0, idx} + (IW + 1)'(2);

  // sequencer and RAM port control
  always_comb begin
    state_next   = state;
    front_next   = front;
    count_next   = count;
    idx_next     = idx;
    status_next  = status_q;
    removed_next = removed_q;
    mem_we       = 1'b0;
    mem_waddr    = slot(front, IW'(count));
    mem_wdata    = val_q;
    mem_raddr    = '0;
    rsp_load     = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        status_next  = ble_pkg::ST_OK;
        removed_next = '0;
        state_next   = S_RESULT;
        if (op_q == ble_pkg::OP_PUSH_FRONT || op_q == ble_pkg::OP_PUSH_BACK) begin
          if (count == CAP_C) begin
            status_next = ble_pkg::ST_FULL;
          end else begin
            mem_we     = 1'b1;
            count_next = count + 1'b1;
            if (op_q == ble_pkg::OP_PUSH_FRONT) begin
              front_next = front_dec;
              mem_waddr  = front_dec;
            end
          end
        end else if (count == '0) begin
          status_next = ble_pkg::ST_EMPTY;
        end else if (op_q == ble_pkg::OP_POP_BACK) begin
          mem_raddr  = slot(front, IW'(count - 1'b1));
          count_next = count - 1'b1;
          state_next = S_POPRD;
        end else if (pos_bad) begin
          status_next = ble_pkg::ST_BADPOS;
        end else begin
          idx_next   = IW'(pos_off);
          mem_raddr  = slot(front, IW'(pos_off));
          state_next = S_VICTIM;
        end
      end
      S_POPRD: begin
        removed_next = mem_rdata;
        state_next   = S_RESULT;
      end
      S_VICTIM: begin
        removed_next = mem_rdata;
        if (CMPW'(idx_p1) < CMPW'(count)) begin
          mem_raddr  = slot(front, idx_p1[IW-1:0]);
          state_next = S_SHIFT;
        end else begin
          count_next = count - 1'b1;
          state_next = S_RESULT;
        end
      end
      S_SHIFT: begin
        // move the element read last cycle one slot towards the front
        mem_we    = 1'b1;
        mem_waddr = slot(front, idx);
        mem_wdata = mem_rdata;
        idx_next  = idx_p1[IW-1:0];
        if (CMPW'(idx_p2) < CMPW'(count)) begin
          mem_raddr = slot(front, idx_p2[IW-1:0]);
        end else begin
          count_next = count - 1'b1;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // command capture, work registers and response payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.valid) begin
      op_q  <= cmd.opcode;
      val_q <= cmd.value;
      pos_q <= cmd.position;
    end
    idx       <= idx_next;
    status_q  <= status_next;
    removed_q <= removed_next;
    if (rsp_load) begin
      rsp_status  <= status_q;
      rsp_length  <= ble_pkg::LEN_W'(count);
      rsp_removed <= removed_q;
    end
  end

  // channel outputs
  assign cmd.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.length        = rsp_length;
  assign rsp.removed_value = rsp_removed;

endmodule

`default_nettype wire

// ----- hdl/ble_ram.sv -----
// ----------------------------------------------------------------------------
// ble_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ble_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
